/* rtl/ctd_pkg.sv */
// Package for the collision time detector: sizes, transaction types and
// queue geometry. Used by every module of the block; depends on nothing.

package ctd_pkg;

  // Alphabet and counter geometry
  localparam int SYMBOL_BITS = 8;
  localparam int COUNT_BITS  = 20;
  localparam int SYM_COUNT   = 1 << SYMBOL_BITS;

  // Fixed widths of the transaction fields
  localparam int IN_SYM_W  = 8;
  localparam int OUT_SYM_W = 8;
  localparam int OUT_CNT_W = 20;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [SYMBOL_BITS-1:0] sym_t;
  typedef logic [COUNT_BITS-1:0]  cnt_t;

  localparam cnt_t CNT_MAX = '1;

  // Input transaction
  typedef struct packed {
    logic [IN_SYM_W-1:0] symbol;
    logic                first;
  } ctd_in_t;

  // Result transaction
  typedef struct packed {
    logic [OUT_SYM_W-1:0] sym_out;
    logic [OUT_CNT_W-1:0] position;
    logic                 hit;
    logic [OUT_CNT_W-1:0] collision_total;
    logic [OUT_CNT_W-1:0] symbol_hits;
    logic                 overflow;
  } ctd_out_t;

  // Classified item as queued between front and back
  typedef struct packed {
    sym_t sym;
    logic first;
  } ctd_item_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } ctd_qstat_t;

endpackage

/* rtl/ctd_front.sv */
// Front end: accepts input transactions, masks the symbol to the alphabet
// and hands the item to the queue. Depends on ctd_pkg.

module ctd_front import ctd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  ctd_in_t    in_item,
  input  ctd_qstat_t q_stat,
  output logic       q_push,
  output ctd_item_t  q_item
);

  logic      f_valid_r, f_valid_nxt;
  ctd_item_t f_item_r;
  logic      accept;

  // Hold off only when the staged item cannot move into the queue
  assign in_stall = f_valid_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = f_valid_r && !q_stat.full;
  assign q_item   = f_item_r;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (accept) begin
      f_valid_nxt = 1'b1;
    end else if (q_push) begin
      f_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Stage register: symbol masked to SYMBOL_BITS
  always_ff @(posedge clk) begin
    if (accept) begin
      f_item_r.sym   <= SYMBOL_BITS'(in_item.symbol);
      f_item_r.first <= in_item.first;
    end
  end

endmodule

/* rtl/ctd_queue.sv */
// Small FIFO that decouples the front end from the back end.
// Depends on ctd_pkg.

module ctd_queue import ctd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ctd_item_t  push_item,
  input  logic       pop,
  output ctd_item_t  head_item,
  output ctd_qstat_t stat
);

  ctd_item_t            entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/ctd_back.sv */
// Back end: two-stage pipeline (count memory read, then collision update)
// feeding an output register. Holds the seen map, per-symbol counts and
// the sequence counters. Depends on ctd_pkg.

module ctd_back import ctd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctd_item_t  q_item,
  input  ctd_qstat_t q_stat,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output ctd_out_t   out_res
);

  // Pipeline registers
  logic      s1_valid_r, s2_valid_r, o_valid_r;
  ctd_item_t s1_item_r, s2_item_r;
  cnt_t      s2_mem_r;
  logic      s2_fwd_r;
  cnt_t      s2_fwd_val_r;
  ctd_out_t  o_res_r;

  // Architectural state
  logic [SYM_COUNT-1:0] seen_r, seen_nxt;
  logic [SYM_COUNT-1:0] cnt_vld_r, cnt_vld_nxt;
  cnt_t                 pos_r, pos_nxt;
  cnt_t                 tot_r, tot_nxt;
  logic                 sat_r, sat_nxt;
  cnt_t                 cnt_mem [SYM_COUNT];

  logic                 adv;
  logic                 upd;
  logic [SYM_COUNT-1:0] sym_bit;
  logic [SYM_COUNT-1:0] seen_base, vld_base;
  logic                 hit;
  cnt_t                 pos_base, tot_base, cnt_base, cnt_nxt;
  logic                 sat_base;
  logic                 pos_ovf, tot_ovf, cnt_ovf;

  // Whole pipeline moves when the output register can take a result
  assign adv   = !o_valid_r || !out_stall;
  assign upd   = adv && s2_valid_r;
  assign q_pop = adv && !q_stat.empty;

  // Collision update for the item in stage 2
  always_comb begin
    sym_bit   = SYM_COUNT'(1) << s2_item_r.sym;
    seen_base = s2_item_r.first ? '0 : seen_r;
    vld_base  = s2_item_r.first ? '0 : cnt_vld_r;
    pos_base  = s2_item_r.first ? '0 : pos_r;
    tot_base  = s2_item_r.first ? '0 : tot_r;
    sat_base  = s2_item_r.first ? 1'b0 : sat_r;

    // Per-symbol count: cleared, forwarded from the previous write, or memory
    if (s2_item_r.first) begin
      cnt_base = '0;
    end else if (s2_fwd_r) begin
      cnt_base = s2_fwd_val_r;
    end else if (cnt_vld_r[s2_item_r.sym]) begin
      cnt_base = s2_mem_r;
    end else begin
      cnt_base = '0;
    end

    hit = seen_base[s2_item_r.sym];

    pos_ovf = (pos_base == CNT_MAX);
    tot_ovf = (tot_base == CNT_MAX);
    cnt_ovf = (cnt_base == CNT_MAX);

    pos_nxt = pos_ovf ? pos_base : pos_base + 1'b1;
    tot_nxt = tot_base;
    cnt_nxt = cnt_base;
    if (hit) begin
      tot_nxt = tot_ovf ? tot_base : tot_base + 1'b1;
      cnt_nxt = cnt_ovf ? cnt_base : cnt_base + 1'b1;
    end
    sat_nxt = sat_base || pos_ovf || (hit && (tot_ovf || cnt_ovf));

    // A collision empties the window; otherwise the symbol joins it
    seen_nxt    = hit ? '0 : (seen_base | sym_bit);
    cnt_vld_nxt = vld_base | sym_bit;
  end

  // Stage valids and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= !q_stat.empty;
      s2_valid_r <= s1_valid_r;
      o_valid_r  <= s2_valid_r;
    end
  end

  // Sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      cnt_vld_r <= '0;
      pos_r     <= '0;
      tot_r     <= '0;
      sat_r     <= 1'b0;
    end else if (upd) begin
      seen_r    <= seen_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      pos_r     <= pos_nxt;
      tot_r     <= tot_nxt;
      sat_r     <= sat_nxt;
    end
  end

  // Payload of stages and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r    <= q_item;
      s2_item_r    <= s1_item_r;
      s2_mem_r     <= cnt_mem[s1_item_r.sym];
      s2_fwd_r     <= s2_valid_r && (s1_item_r.sym == s2_item_r.sym);
      s2_fwd_val_r <= cnt_nxt;
      o_res_r.sym_out         <= OUT_SYM_W'(s2_item_r.sym);
      o_res_r.position        <= OUT_CNT_W'(pos_nxt);
      o_res_r.hit             <= hit;
      o_res_r.collision_total <= OUT_CNT_W'(tot_nxt);
      o_res_r.symbol_hits     <= OUT_CNT_W'(cnt_nxt);
      o_res_r.overflow        <= sat_nxt;
    end
  end

  // Per-symbol count memory, written back every transaction
  always_ff @(posedge clk) begin
    if (upd) begin
      cnt_mem[s2_item_r.sym] <= cnt_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_res   = o_res_r;

endmodule

/* rtl/collision_time_detector_top.sv */
// Collision time detector: one symbol per clock unless a stall holds the
// flow; a symbol passes the input stage, queue, memory read, update and
// output register. Throughput one transaction per cycle when not stalled;
// the count memory is read one stage ahead and forwarded on back-to-back
// repeats of a symbol. Synchronous active-low reset empties the pipeline and
// clears the seen map, per-symbol valid bits and counters; no clearing pass.

module collision_time_detector_top import ctd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctd_in_t  in_item,
  output logic     out_valid,
  input  logic     out_stall,
  output ctd_out_t out_res
);

  logic       q_push, q_pop;
  ctd_item_t  q_in_item, q_head_item;
  ctd_qstat_t q_stat;

  ctd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_item   (q_in_item)
  );

  ctd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  ctd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_head_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

/* rtl/ctd_checker.sv */
// Port-level checks for the collision time detector, bound to the top level.
// Depends on ctd_pkg.

module ctd_checker import ctd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input ctd_in_t  in_item,
  input logic     out_valid,
  input logic     out_stall,
  input ctd_out_t out_res
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

  // No result straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Positions are 1-based
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.position != '0)
    else $error("zero position");

  // A collision is counted both in total and for its symbol
  a_hit_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.hit |->
      (out_res.collision_total != '0) && (out_res.symbol_hits != '0))
    else $error("collision without counts");

  // The first symbol of a sequence meets an empty window and cannot collide
  a_no_hit_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.position == OUT_CNT_W'(1) |-> !out_res.hit)
    else $error("collision on first symbol");

  logic unused_in;
  assign unused_in = in_valid ^ in_stall ^ (^in_item);

endmodule

bind collision_time_detector_top ctd_checker u_ctd_checker (.*);

/* dv/collision_time_detector_checker.sv */
// Checker for the collision time detector: tracks the collision windows and
// counters alongside the block and compares every result transaction.
// Depends on ctd_pkg for the transaction types and the alphabet geometry.
`timescale 1ns / 1ps

module collision_time_detector_checker import ctd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ctd_in_t  in_item,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ctd_out_t out_res,
  output int       fail_count,
  output int       pending_count
);

  // Shadow state of the detector
  logic [SYM_COUNT-1:0] window_seen;
  cnt_t                 sym_hit_count [SYM_COUNT];
  cnt_t                 pos_count;
  cnt_t                 coll_count;
  logic                 overflow_flag;

  ctd_out_t expected_q [$];
  int       mismatches = 0;

  // Saturating increment; bumping a counter already at max flags overflow
  function automatic cnt_t sat_bump(cnt_t v);
    if (v == CNT_MAX) begin
      overflow_flag = 1'b1;
      return v;
    end
    return v + 1'b1;
  endfunction

  function automatic void clear_stats();
    window_seen = '0;
    for (int i = 0; i < SYM_COUNT; i++) sym_hit_count[i] = '0;
    pos_count     = '0;
    coll_count    = '0;
    overflow_flag = 1'b0;
  endfunction

  // Advance the shadow state by one symbol and build the expected result
  function automatic ctd_out_t predict_collision(ctd_in_t item);
    ctd_out_t r;
    sym_t     s;
    s = item.symbol[SYMBOL_BITS-1:0];
    if (item.first) clear_stats();
    pos_count = sat_bump(pos_count);
    r.hit = window_seen[s];
    if (window_seen[s]) begin
      coll_count       = sat_bump(coll_count);
      sym_hit_count[s] = sat_bump(sym_hit_count[s]);
      window_seen      = '0;  // next window starts empty after this symbol
    end else begin
      window_seen[s] = 1'b1;
    end
    r.sym_out         = OUT_SYM_W'(s);
    r.position        = OUT_CNT_W'(pos_count);
    r.collision_total = OUT_CNT_W'(coll_count);
    r.symbol_hits     = OUT_CNT_W'(sym_hit_count[s]);
    r.overflow        = overflow_flag;
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch in %s: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Monitor both channels at the rising edge
  always @(posedge clk) begin : monitor
    ctd_out_t want;
    if (!rst_n) begin
      clear_stats();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result transaction with nothing outstanding: sym %0d pos %0d",
                     $realtime, out_res.sym_out, out_res.position);
        end else begin
          want = expected_q.pop_front();
          check_field("sym_out", want.sym_out, out_res.sym_out);
          check_field("position", want.position, out_res.position);
          check_field("hit", want.hit, out_res.hit);
          check_field("collision_total", want.collision_total, out_res.collision_total);
          check_field("symbol_hits", want.symbol_hits, out_res.symbol_hits);
          check_field("overflow", want.overflow, out_res.overflow);
        end
      end
      if (in_valid && !in_stall) begin
        expected_q.insert(expected_q.size(), predict_collision(in_item));
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_q.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the collision time detector testbench: clock, reset, symbol
// stimulus and verdict. Depends on ctd_pkg, the block and the checker.
`timescale 1ns / 1ps

module testbench;
  import ctd_pkg::*;

  localparam int CYCLE_LIMIT  = 100_000;
  localparam int RANDOM_ITEMS = 1300;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ctd_in_t  in_item   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ctd_out_t out_res;
  int       fail_count;
  int       pending_count;
  int       cycle_count = 0;
  bit       quiet       = 1'b0;  // no idling on either side while set

  always #5 clk = ~clk;

  collision_time_detector_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  collision_time_detector_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Result side backpressure
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 25);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Present one symbol transaction and hold it until accepted
  task automatic send_symbol(input logic [IN_SYM_W-1:0] sym, input logic first);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ctd_in_t'{symbol: sym, first: first};
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    logic narrow;
    logic first;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset acts as sequence start, extremes, window restart, first flag
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b0);  // window was cleared, so no hit
    send_symbol(8'hAA, 1'b0);  // repeat inside the new window: hit
    send_symbol(8'h05, 1'b0);
    send_symbol(8'h05, 1'b1);  // first flag wipes the window: no hit, position 1
    send_symbol(8'h05, 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b0);
    drain_results();

    // Random sequences; a small alphabet gives frequent collisions
    narrow = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 500 && i < 800);
      first = ($urandom_range(99) < 3);
      if (first) narrow = 1'($urandom_range(1));
      send_symbol(narrow ? IN_SYM_W'($urandom_range(7)) : IN_SYM_W'($urandom_range(255)),
                  first);
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ctd_pkg.sv
rtl/ctd_front.sv
rtl/ctd_queue.sv
rtl/ctd_back.sv
rtl/collision_time_detector_top.sv
rtl/ctd_checker.sv
dv/collision_time_detector_checker.sv
dv/testbench.sv
